FILE: rtl/core/hbcs_pkg.sv
// ----------------------------------------------------------------------------
// hbcs_pkg
// Types and constants for the hue blob centroid steering unit.
// ----------------------------------------------------------------------------
`default_nettype none

package hbcs_pkg;

   // sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_DIV_COL = 4'b0010,
      ST_DIV_ROW = 4'b0100,
      ST_OUT     = 4'b1000
   } hbcs_state_type;

   // register index, byte address is 4 * index
   typedef enum logic [2:0] {
      REG_HUE_MIN     = 3'd0,
      REG_HUE_MAX     = 3'd1,
      REG_CENTRE_LOW  = 3'd2,
      REG_CENTRE_HIGH = 3'd3,
      REG_OUTER_LOW   = 3'd4,
      REG_OUTER_HIGH  = 3'd5,
      REG_NEAR_COUNT  = 3'd6
   } hbcs_reg_type;

   localparam int CSR_ADDR_W = 5;
   localparam int SUM_W      = 30;
   localparam int COUNT_W    = 21;
   localparam int COORD_W    = 10;
   localparam int HUE_W      = 8;

   // reset values of the registers
   localparam logic [7:0]  HUE_MIN_RST     = 8'd102;
   localparam logic [7:0]  HUE_MAX_RST     = 8'd125;
   localparam logic [9:0]  CENTRE_LOW_RST  = 10'd300;
   localparam logic [9:0]  CENTRE_HIGH_RST = 10'd340;
   localparam logic [9:0]  OUTER_LOW_RST   = 10'd270;
   localparam logic [9:0]  OUTER_HIGH_RST  = 10'd370;
   localparam logic [20:0] NEAR_COUNT_RST  = 21'd1900;

   // steering commands in tenths
   localparam logic [1:0]        FWD_STOP     = 2'd0;
   localparam logic [1:0]        FWD_SLOW     = 2'd1;
   localparam logic [1:0]        FWD_FAST     = 2'd2;
   localparam logic signed [3:0] TURN_NONE    = 4'sd0;
   localparam logic signed [3:0] TURN_LEFT    = 4'sd1;
   localparam logic signed [3:0] TURN_RIGHT   = -4'sd1;
   localparam logic signed [3:0] TURN_DEFAULT = 4'sd2;
   localparam logic signed [3:0] TURN_SEARCH  = 4'sd5;

endpackage

`default_nettype wire

FILE: rtl/core/hue_blob_centroid_steering_unit.sv
// ----------------------------------------------------------------------------
// hue_blob_centroid_steering_unit
// Hue-threshold blob centroid tracker with a steering command output.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries pixels and decide transactions. req_tuser[0] is the
//   action (0 pixel, 1 decide), req_tuser[1] is frame_start. A pixel with a
//   matching hue adds its column and row to the sums.
//   A decide transaction starts the divider: one shared restoring subtract
//   unit produces one quotient bit per cycle, first for the centroid column
//   and then for the row. The result is registered on the rsp channel from
//   the ST_OUT state, which a decide enters directly when no pixel matched;
//   req_tready is low from the decide until the result is loaded.
//   Pixels keep one per cycle while the unit is idle and are accepted while a
//   result waits on rsp. If the output register is full and rsp_tready is low,
//   a ready result is held in the sequencer and nothing is accepted until the
//   output register frees. Registers are written over the csr port (APB
//   style, pready always high) and the user must change them only while the
//   unit is idle; the unit does not enforce this. Synchronous reset restores
//   the register defaults, clears sums, count, the sequencer and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module hue_blob_centroid_steering_unit #(
   parameter int MAX_COLS = 1024,
   parameter int MAX_ROWS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // hue[7:0], col[17:8], row[27:18], zero pad
   input  wire logic [1:0]  req_tuser,   // action[0], frame_start[1]
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // forward_tenths[1:0], turn_tenths[5:2], blob_seen[6], target_close[7],
   // centroid_col[17:8], centroid_row[27:18], zero pad
   output logic [31:0]      rsp_tdata,
   // configuration port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [hbcs_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [12:0] COL_LIMIT = 13'(MAX_COLS);
   localparam logic [12:0] ROW_LIMIT = 13'(MAX_ROWS);

   // configuration registers
   logic [7:0]  hue_min_ff, hue_max_ff;
   logic [9:0]  centre_low_ff, centre_high_ff, outer_low_ff, outer_high_ff;
   logic [20:0] near_count_ff;

   // accumulators
   logic [hbcs_pkg::SUM_W-1:0]   col_sum_ff, col_sum_in;
   logic [hbcs_pkg::SUM_W-1:0]   row_sum_ff, row_sum_in;
   logic [hbcs_pkg::COUNT_W-1:0] count_ff, count_in;

   // sequencer and divider
   hbcs_pkg::hbcs_state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [20:0] rem_ff, rem_in;
   logic [9:0]  dsh_ff, dsh_in;
   logic [9:0]  quo_ff, quo_in;
   logic [9:0]  pc_ff, pc_in;
   logic [9:0]  pr_ff, pr_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // request fields
   logic       req_action, req_frame_start;
   logic [7:0] req_hue;
   logic [9:0] req_col, req_row;
   logic       req_fire, rsp_free, csr_write;

   // divider step
   logic [21:0] trial;
   logic        qbit;
   logic [20:0] rem_next;
   logic [9:0]  quo_next;

   // pixel path
   logic [hbcs_pkg::SUM_W-1:0]   col_base, row_base;
   logic [hbcs_pkg::COUNT_W-1:0] count_base;
   logic                         pix_match;

   // steering
   logic [1:0]        cmd_fwd;
   logic signed [3:0] cmd_turn;
   logic              cmd_seen, cmd_close;

   assign req_action      = req_tuser[0];
   assign req_frame_start = req_tuser[1];
   assign req_hue         = req_tdata[7:0];
   assign req_col         = req_tdata[17:8];
   assign req_row         = req_tdata[27:18];

   assign req_tready = (state_ff == hbcs_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      unique case (hbcs_pkg::hbcs_reg_type'(csr_paddr[4:2]))
         hbcs_pkg::REG_HUE_MIN:     csr_prdata = {24'd0, hue_min_ff};
         hbcs_pkg::REG_HUE_MAX:     csr_prdata = {24'd0, hue_max_ff};
         hbcs_pkg::REG_CENTRE_LOW:  csr_prdata = {22'd0, centre_low_ff};
         hbcs_pkg::REG_CENTRE_HIGH: csr_prdata = {22'd0, centre_high_ff};
         hbcs_pkg::REG_OUTER_LOW:   csr_prdata = {22'd0, outer_low_ff};
         hbcs_pkg::REG_OUTER_HIGH:  csr_prdata = {22'd0, outer_high_ff};
         hbcs_pkg::REG_NEAR_COUNT:  csr_prdata = {11'd0, near_count_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_min_ff     <= hbcs_pkg::HUE_MIN_RST;
         hue_max_ff     <= hbcs_pkg::HUE_MAX_RST;
         centre_low_ff  <= hbcs_pkg::CENTRE_LOW_RST;
         centre_high_ff <= hbcs_pkg::CENTRE_HIGH_RST;
         outer_low_ff   <= hbcs_pkg::OUTER_LOW_RST;
         outer_high_ff  <= hbcs_pkg::OUTER_HIGH_RST;
         near_count_ff  <= hbcs_pkg::NEAR_COUNT_RST;
      end else if (csr_write) begin
         unique case (hbcs_pkg::hbcs_reg_type'(csr_paddr[4:2]))
            hbcs_pkg::REG_HUE_MIN:     hue_min_ff     <= csr_pwdata[7:0];
            hbcs_pkg::REG_HUE_MAX:     hue_max_ff     <= csr_pwdata[7:0];
            hbcs_pkg::REG_CENTRE_LOW:  centre_low_ff  <= csr_pwdata[9:0];
            hbcs_pkg::REG_CENTRE_HIGH: centre_high_ff <= csr_pwdata[9:0];
            hbcs_pkg::REG_OUTER_LOW:   outer_low_ff   <= csr_pwdata[9:0];
            hbcs_pkg::REG_OUTER_HIGH:  outer_high_ff  <= csr_pwdata[9:0];
            hbcs_pkg::REG_NEAR_COUNT:  near_count_ff  <= csr_pwdata[20:0];
            default: ;
         endcase
      end
   end

   // -------------------------------------------------------------- pixel path
   always_comb begin
      col_base   = req_frame_start ? '0 : col_sum_ff;
      row_base   = req_frame_start ? '0 : row_sum_ff;
      count_base = req_frame_start ? '0 : count_ff;
      // top count bit set means a full frame has been counted
      pix_match  = (req_hue >= hue_min_ff) && (req_hue <= hue_max_ff) &&
                   ({3'b000, req_col} < COL_LIMIT) && ({3'b000, req_row} < ROW_LIMIT) &&
                   !count_base[hbcs_pkg::COUNT_W-1];
   end

   always_comb begin
      col_sum_in = col_sum_ff;
      row_sum_in = row_sum_ff;
      count_in   = count_ff;
      if (req_fire && !req_action) begin
         col_sum_in = pix_match ? col_base + hbcs_pkg::SUM_W'(req_col) : col_base;
         row_sum_in = pix_match ? row_base + hbcs_pkg::SUM_W'(req_row) : row_base;
         count_in   = pix_match ? count_base + 1'b1 : count_base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_sum_ff <= '0;
         row_sum_ff <= '0;
         count_ff   <= '0;
      end else begin
         col_sum_ff <= col_sum_in;
         row_sum_ff <= row_sum_in;
         count_ff   <= count_in;
      end
   end

   // ---------------------------------------------------------------- divider
   // quotient is below 1024, so the upper sum bits start out below the count
   always_comb begin
      trial    = {rem_ff, dsh_ff[9]};
      qbit     = (trial >= {1'b0, count_ff});
      rem_next = qbit ? 21'(trial - {1'b0, count_ff}) : trial[20:0];
      quo_next = {quo_ff[8:0], qbit};
   end

   // -------------------------------------------------------------- steering
   always_comb begin
      cmd_seen  = (count_ff != '0);
      cmd_close = 1'b0;
      cmd_fwd   = hbcs_pkg::FWD_STOP;
      cmd_turn  = hbcs_pkg::TURN_SEARCH;
      if (cmd_seen) begin
         priority if (pc_ff >= centre_low_ff && pc_ff <= centre_high_ff) begin
            cmd_fwd  = hbcs_pkg::FWD_FAST;
            cmd_turn = hbcs_pkg::TURN_NONE;
         end else if (pc_ff >= outer_low_ff && pc_ff <= centre_low_ff) begin
            cmd_fwd  = hbcs_pkg::FWD_SLOW;
            cmd_turn = hbcs_pkg::TURN_LEFT;
         end else if (pc_ff >= centre_high_ff && pc_ff <= outer_high_ff) begin
            cmd_fwd  = hbcs_pkg::FWD_SLOW;
            cmd_turn = hbcs_pkg::TURN_RIGHT;
         end else begin
            cmd_fwd  = hbcs_pkg::FWD_STOP;
            cmd_turn = hbcs_pkg::TURN_DEFAULT;
         end
         if (count_ff >= near_count_ff) begin
            cmd_fwd   = hbcs_pkg::FWD_STOP;
            cmd_turn  = hbcs_pkg::TURN_NONE;
            cmd_close = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      quo_in       = quo_ff;
      pc_in        = pc_ff;
      pr_in        = pr_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         hbcs_pkg::ST_IDLE: begin
            if (req_fire && req_action) begin
               step_in = '0;
               quo_in  = '0;
               rem_in  = {1'b0, col_sum_ff[29:10]};
               dsh_in  = col_sum_ff[9:0];
               if (count_ff == '0) begin
                  pc_in    = '0;
                  pr_in    = '0;
                  state_in = hbcs_pkg::ST_OUT;
               end else begin
                  state_in = hbcs_pkg::ST_DIV_COL;
               end
            end
         end
         hbcs_pkg::ST_DIV_COL: begin
            rem_in  = rem_next;
            dsh_in  = {dsh_ff[8:0], 1'b0};
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd9) begin
               pc_in    = quo_next;
               step_in  = '0;
               quo_in   = '0;
               rem_in   = {1'b0, row_sum_ff[29:10]};
               dsh_in   = row_sum_ff[9:0];
               state_in = hbcs_pkg::ST_DIV_ROW;
            end
         end
         hbcs_pkg::ST_DIV_ROW: begin
            rem_in  = rem_next;
            dsh_in  = {dsh_ff[8:0], 1'b0};
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == 4'd9) begin
               pr_in    = quo_next;
               state_in = hbcs_pkg::ST_OUT;
            end
         end
         hbcs_pkg::ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, pr_ff, pc_ff, cmd_close, cmd_seen, cmd_turn, cmd_fwd};
               state_in     = hbcs_pkg::ST_IDLE;
            end
         end
         default: state_in = hbcs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbcs_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      pc_ff       <= pc_in;
      pr_ff       <= pr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ------------------------------------------------------------ assertions
   // partial remainder stays below the divisor during a division
   a_rem_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hbcs_pkg::ST_DIV_COL || state_ff == hbcs_pkg::ST_DIV_ROW)
      |-> (rem_ff < count_ff))
      else $error("divider remainder not below count");

   // a near target stops the robot
   a_close_stops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[7]) |-> (rsp_data_ff[5:0] == 6'd0 && rsp_data_ff[6]))
      else $error("target_close without stop command");

   // no blob gives search spin and a zero centroid
   a_no_blob_search: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff[6])
      |-> (rsp_data_ff[5:2] == hbcs_pkg::TURN_SEARCH && rsp_data_ff[27:8] == 20'd0))
      else $error("no-blob response malformed");

   // a decide with an empty count skips the divider
   a_empty_skips_divide: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_action && count_ff == '0) |=> (state_ff == hbcs_pkg::ST_OUT))
      else $error("empty decide entered divider");

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for hue_blob_centroid_steering_unit.
// Pixel and decide transactions go through the unit under several register
// settings, directed first and random after. The testbench tracks the column
// and row sums and the count on its own, works out each steering command and
// checks every response field against it, with random idling on both streams.
// ----------------------------------------------------------------------------
module tb;

   localparam bit          ACT_PIXEL     = 1'b0;
   localparam bit          ACT_DECIDE    = 1'b1;
   localparam int          FRAME_COLS    = 1024;
   localparam int          FRAME_ROWS    = 1024;
   localparam int unsigned COUNT_CAP     = 1048576;
   localparam int          QUIET_LIMIT   = 5000;
   localparam int          SETTLE_CYCLES = 30;
   localparam int          LONG_HOLD     = 400;
   localparam int          HOLD_AFTER    = 30;

   // response layout, lowest field last
   typedef struct packed {
      logic [9:0]        row;
      logic [9:0]        col;
      logic              close;
      logic              seen;
      logic signed [3:0] turn;
      logic [1:0]        fwd;
   } steer_cmd_type;

   typedef struct {
      bit       act;
      bit       fs;
      bit [7:0] hue;
      bit [9:0] col;
      bit [9:0] row;
   } pixel_op_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;   // hue[7:0], col[17:8], row[27:18], zero pad
   logic [1:0]            req_tuser;   // action[0], frame_start[1]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // forward[1:0], turn[5:2], blob_seen[6], target_close[7], centroid_col[17:8],
   // centroid_row[27:18], zero pad
   logic [31:0]           rsp_tdata;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [hbcs_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // register shadows
   logic [7:0]  cfg_hue_min;
   logic [7:0]  cfg_hue_max;
   logic [9:0]  cfg_centre_low;
   logic [9:0]  cfg_centre_high;
   logic [9:0]  cfg_outer_low;
   logic [9:0]  cfg_outer_high;
   logic [20:0] cfg_near_count;

   // blob accumulators
   logic [29:0] acc_col;
   logic [29:0] acc_row;
   logic [20:0] hit_count;

   pixel_op_type  pending_ops[$];
   steer_cmd_type steer_expected[$];

   int errors;
   int rsp_count;
   int quiet_cycles;
   int idle_odds;
   int req_gap;
   int rsp_stall;
   int long_hold;
   bit long_done;
   bit req_hs;

   hue_blob_centroid_steering_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   task automatic absorb_op(input logic act, input logic fs, input logic [7:0] hue,
                            input logic [9:0] col, input logic [9:0] row);
      steer_cmd_type cmd;
      logic [29:0]   mean_col;
      logic [29:0]   mean_row;
      if (act == ACT_PIXEL) begin
         if (fs) begin
            acc_col   = '0;
            acc_row   = '0;
            hit_count = '0;
         end
         if (hue >= cfg_hue_min && hue <= cfg_hue_max && col < FRAME_COLS &&
             row < FRAME_ROWS && hit_count < COUNT_CAP) begin
            acc_col   = acc_col + col;
            acc_row   = acc_row + row;
            hit_count = hit_count + 1'b1;
         end
      end else begin
         cmd = '0;
         if (hit_count == 0) begin
            cmd.fwd  = hbcs_pkg::FWD_STOP;
            cmd.turn = hbcs_pkg::TURN_SEARCH;
         end else begin
            mean_col = acc_col / hit_count;
            mean_row = acc_row / hit_count;
            cmd.seen = 1'b1;
            cmd.col  = mean_col[9:0];
            cmd.row  = mean_row[9:0];
            cmd.fwd  = hbcs_pkg::FWD_STOP;
            cmd.turn = hbcs_pkg::TURN_DEFAULT;
            // first band that holds the centroid wins
            if (cmd.col >= cfg_centre_low && cmd.col <= cfg_centre_high) begin
               cmd.fwd  = hbcs_pkg::FWD_FAST;
               cmd.turn = hbcs_pkg::TURN_NONE;
            end else if (cmd.col >= cfg_outer_low && cmd.col <= cfg_centre_low) begin
               cmd.fwd  = hbcs_pkg::FWD_SLOW;
               cmd.turn = hbcs_pkg::TURN_LEFT;
            end else if (cmd.col >= cfg_centre_high && cmd.col <= cfg_outer_high) begin
               cmd.fwd  = hbcs_pkg::FWD_SLOW;
               cmd.turn = hbcs_pkg::TURN_RIGHT;
            end
            if (hit_count >= cfg_near_count) begin
               cmd.fwd   = hbcs_pkg::FWD_STOP;
               cmd.turn  = hbcs_pkg::TURN_NONE;
               cmd.close = 1'b1;
            end
         end
         steer_expected.push_back(cmd);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t rsp %s mismatch: expected %0d actual %0d", $time, name, want_v, got_v);
      end
   endtask

   // ------------------------------------------------------------------------
   // monitor, sampled at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      steer_cmd_type got;
      steer_cmd_type want;
      if (reset) begin
         req_hs <= 1'b0;
      end else begin
         req_hs <= req_tvalid && req_tready;
         // results come from earlier decides, so check before taking the new one
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got = rsp_tdata[27:0];
            if (steer_expected.size() == 0) begin
               errors++;
               $display("%0t rsp unexpected transaction: expected none actual %h",
                        $time, rsp_tdata);
            end else begin
               want = steer_expected.pop_front();
               check_field("forward_tenths", want.fwd, got.fwd);
               check_field("turn_tenths", want.turn, got.turn);
               check_field("blob_seen", want.seen, got.seen);
               check_field("target_close", want.close, got.close);
               check_field("centroid_col", want.col, got.col);
               check_field("centroid_row", want.row, got.row);
               check_field("pad", 32'd0, rsp_tdata[31:28]);
            end
         end
         if (req_tvalid && req_tready)
            absorb_op(req_tuser[0], req_tuser[1], req_tdata[7:0], req_tdata[17:8],
                      req_tdata[27:18]);
      end
   end

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      pixel_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_hs) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            op = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, op.row, op.col, op.hue};
            req_tuser  <= {op.fs, op.act};
            // gap starts once this transaction is taken
            if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0)
               req_gap = $urandom_range(1, 16);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response ready, with one long hold-off to back the unit up
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold > 0) begin
         long_hold--;
         rsp_tready <= 1'b0;
      end else if (!long_done && rsp_count >= HOLD_AFTER) begin
         long_done = 1'b1;
         long_hold = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (idle_odds > 0 && $urandom_range(0, idle_odds - 1) == 0) begin
         rsp_stall = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic csr_write(input hbcs_pkg::hbcs_reg_type idx, input logic [31:0] val);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         hbcs_pkg::REG_HUE_MIN:     cfg_hue_min     = val[7:0];
         hbcs_pkg::REG_HUE_MAX:     cfg_hue_max     = val[7:0];
         hbcs_pkg::REG_CENTRE_LOW:  cfg_centre_low  = val[9:0];
         hbcs_pkg::REG_CENTRE_HIGH: cfg_centre_high = val[9:0];
         hbcs_pkg::REG_OUTER_LOW:   cfg_outer_low   = val[9:0];
         hbcs_pkg::REG_OUTER_HIGH:  cfg_outer_high  = val[9:0];
         hbcs_pkg::REG_NEAR_COUNT:  cfg_near_count  = val[20:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int hmin, input int hmax, input int cl, input int ch,
                             input int ol, input int oh, input int near);
      csr_write(hbcs_pkg::REG_HUE_MIN, hmin);
      csr_write(hbcs_pkg::REG_HUE_MAX, hmax);
      csr_write(hbcs_pkg::REG_CENTRE_LOW, cl);
      csr_write(hbcs_pkg::REG_CENTRE_HIGH, ch);
      csr_write(hbcs_pkg::REG_OUTER_LOW, ol);
      csr_write(hbcs_pkg::REG_OUTER_HIGH, oh);
      csr_write(hbcs_pkg::REG_NEAR_COUNT, near);
   endtask

   task automatic push_op(input bit act, input bit fs, input int hue, input int col,
                          input int row);
      pixel_op_type op;
      op.act = act;
      op.fs  = fs;
      op.hue = 8'(hue);
      op.col = 10'(col);
      op.row = 10'(row);
      pending_ops.push_back(op);
   endtask

   // mostly whole frames clustered near a band edge, some stray transactions
   task automatic fill_random(input int n);
      int added;
      int frame_len;
      int centre;
      int v;
      int j;
      pixel_op_type op;
      added = 0;
      while (added < n) begin
         if ($urandom_range(0, 9) < 8) begin
            frame_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            case ($urandom_range(0, 4))
               0:       centre = cfg_outer_low;
               1:       centre = cfg_centre_low;
               2:       centre = cfg_centre_high;
               3:       centre = cfg_outer_high;
               default: centre = $urandom_range(0, 1023);
            endcase
            centre = centre + int'($urandom_range(0, 40)) - 20;
            for (j = 0; j < frame_len; j++) begin
               op.act = ACT_PIXEL;
               op.fs  = (j == 0);
               if ($urandom_range(0, 4) != 0 && cfg_hue_min <= cfg_hue_max)
                  op.hue = 8'($urandom_range(cfg_hue_min, cfg_hue_max));
               else
                  op.hue = 8'($urandom);
               v = centre + int'($urandom_range(0, 8)) - 4;
               if (v < 0) v = 0;
               if (v > 1023) v = 1023;
               op.col = 10'(v);
               op.row = 10'($urandom);
               pending_ops.push_back(op);
            end
            op.act = ACT_DECIDE;
            op.fs  = 1'($urandom_range(0, 1));
            op.hue = 8'($urandom);
            op.col = 10'($urandom);
            op.row = 10'($urandom);
            pending_ops.push_back(op);
            added += frame_len + 1;
         end else begin
            op.act = ($urandom_range(0, 3) == 0) ? ACT_DECIDE : ACT_PIXEL;
            op.fs  = 1'($urandom_range(0, 1));
            op.hue = 8'($urandom);
            op.col = 10'($urandom);
            op.row = 10'($urandom);
            pending_ops.push_back(op);
            added++;
         end
      end
   endtask

   // sender waits until every command is back and the unit has gone quiet
   task automatic settle();
      while (pending_ops.size() > 0 || req_tvalid) @(posedge clock);
      while (steer_expected.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int k;
      int ol;
      int cl;
      int ch;
      int oh;
      int hmin;
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      errors      = 0;
      rsp_count   = 0;
      req_gap     = 0;
      rsp_stall   = 0;
      long_hold   = 0;
      long_done   = 1'b0;
      idle_odds   = 6;
      cfg_hue_min     = hbcs_pkg::HUE_MIN_RST;
      cfg_hue_max     = hbcs_pkg::HUE_MAX_RST;
      cfg_centre_low  = hbcs_pkg::CENTRE_LOW_RST;
      cfg_centre_high = hbcs_pkg::CENTRE_HIGH_RST;
      cfg_outer_low   = hbcs_pkg::OUTER_LOW_RST;
      cfg_outer_high  = hbcs_pkg::OUTER_HIGH_RST;
      cfg_near_count  = hbcs_pkg::NEAR_COUNT_RST;
      acc_col   = '0;
      acc_row   = '0;
      hit_count = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, register defaults
      push_op(ACT_DECIDE, 0, 0, 0, 0);          // no pixel since reset
      push_op(ACT_DECIDE, 1, 255, 1023, 1023);  // frame start ignored on decide
      push_op(ACT_PIXEL, 1, 0, 0, 0);           // hue below window
      push_op(ACT_PIXEL, 0, 255, 1023, 1023);   // hue above window
      push_op(ACT_DECIDE, 0, 0, 0, 0);
      push_op(ACT_PIXEL, 1, 102, 320, 1023);    // window edges, centre band
      push_op(ACT_PIXEL, 0, 125, 320, 0);
      push_op(ACT_DECIDE, 0, 0, 0, 0);
      push_op(ACT_DECIDE, 1, 0, 0, 0);          // decide keeps the sums
      push_op(ACT_PIXEL, 1, 110, 270, 7);       // left band edge
      push_op(ACT_DECIDE, 0, 0, 0, 0);
      push_op(ACT_PIXEL, 1, 110, 370, 9);       // right band edge
      push_op(ACT_DECIDE, 0, 0, 0, 0);
      push_op(ACT_PIXEL, 1, 110, 1023, 1023);   // outside every band
      push_op(ACT_PIXEL, 0, 101, 0, 0);
      push_op(ACT_PIXEL, 0, 126, 0, 0);
      push_op(ACT_DECIDE, 0, 0, 0, 0);
      push_op(ACT_PIXEL, 1, 110, 0, 0);
      push_op(ACT_DECIDE, 0, 0, 0, 0);
      fill_random(220);
      settle();

      // widest window, near count zero so every blob stops the robot
      set_config(0, 255, 0, 1023, 0, 1023, 0);
      idle_odds = 3;
      fill_random(240);
      settle();

      // inverted hue window
      set_config(200, 50, 600, 400, 700, 300, 21'h1FFFFF);
      idle_odds = 12;
      fill_random(200);
      settle();

      // misordered band edges
      set_config(255, 255, 500, 400, 450, 800, 21'h1FFFFF);
      idle_odds = 0;
      fill_random(240);
      settle();

      set_config(0, 0, 1023, 1023, 0, 1023, 1);
      idle_odds = 6;
      fill_random(240);
      settle();

      for (k = 0; k < 4; k++) begin
         hmin = $urandom_range(0, 200);
         ol   = $urandom_range(0, 400);
         cl   = ol + int'($urandom_range(0, 150));
         ch   = cl + int'($urandom_range(0, 150));
         oh   = ch + int'($urandom_range(0, 150));
         set_config(hmin, hmin + int'($urandom_range(0, 55)), cl, ch, ol, oh,
                    $urandom_range(1, 40));
         // last stretch runs without idling
         idle_odds = (k == 3) ? 0 : 3 * (k + 1);
         fill_random(200);
         settle();
      end

      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
